FILE: rtl/core/pee_pkg.sv
// Shared types, constants and command/status structures for the postfix evaluator.
// Depends on nothing; used by the controller, the datapath and the top level.
package pee_pkg;

	localparam int unsigned DefStackDepth = 64;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChMul   = 8'h2A;
	localparam logic [7:0] ChDiv   = 8'h2F;
	localparam logic [7:0] ChPow   = 8'h24;
	localparam logic [7:0] ChMod   = 8'h25;

	localparam logic [2:0] StOk      = 3'd0;
	localparam logic [2:0] StUnder   = 3'd1;
	localparam logic [2:0] StOver    = 3'd2;
	localparam logic [2:0] StZdiv    = 3'd3;
	localparam logic [2:0] StUnknown = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MOD = 3'd4,
		OP_POW = 3'd5
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		logic       rd_b;     // read top entry into b
		logic       rd_a;     // read entry below top into a
		logic       push_dig; // write digit at level and increment
		logic       start;    // start arithmetic on a, b
		logic       wr_res;   // write result at level-2, decrement
		logic       rd_top;   // read top entry for the result word
		logic       clr;      // empty the stack
		op_t        op;
		logic [3:0] digit;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic done;      // arithmetic finished
		logic b_zero;
		logic empty;
		logic full;
		logic lt2;
	} sts_t;

endpackage

FILE: rtl/core/pee_datapath.sv
// Datapath of the postfix evaluator: operand stack memory, level counter,
// and the iterative multiply / divide / power unit. Depends on pee_pkg.
module pee_datapath import pee_pkg::*; #(
	parameter int unsigned STACK_DEPTH = DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [31:0] rd_data
);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic [LW-1:0] level_q;
	logic [31:0] rdat_q, a_q, b_q;

	// Iterative unit state.
	logic        busy_q, done_q;
	op_t         op_q;
	logic [5:0]  cnt_q;
	logic [31:0] acc_q, base_q, exp_q, rem_q, quo_q, dvs_q;
	logic        na_q, nb_q;

	logic [LW-1:0] lm1, lm2;
	assign lm1 = level_q - LW'(1);
	assign lm2 = level_q - LW'(2);

	logic [AW-1:0] raddr;
	always_comb begin
		raddr = lm1[AW-1:0];
		if (cmd.rd_a) raddr = lm2[AW-1:0];
	end

	logic [31:0] result;

	always_ff @(posedge clk) begin
		if (cmd.push_dig) mem[level_q[AW-1:0]] <= {28'd0, cmd.digit};
		else if (cmd.wr_res) mem[lm2[AW-1:0]] <= result;
		rdat_q <= mem[raddr];
	end

	// Read data is registered in rdat_q; delayed rd_b/rd_a then latch it into b or a.
	logic rd_b_d, rd_a_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			rd_b_d  <= 1'b0;
			rd_a_d  <= 1'b0;
		end else begin
			rd_b_d <= cmd.rd_b;
			rd_a_d <= cmd.rd_a;
			if (cmd.clr) level_q <= '0;
			else if (cmd.push_dig) level_q <= level_q + LW'(1);
			else if (cmd.wr_res) level_q <= lm1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_b_d) b_q <= rdat_q;
		if (rd_a_d) a_q <= rdat_q;
	end

	// Restoring division step on magnitudes.
	logic [32:0] trial;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	logic [31:0] ua, ub;
	assign ua = a_q[31] ? (32'd0 - a_q) : a_q;
	assign ub = b_q[31] ? (32'd0 - b_q) : b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= cmd.op;
			cnt_q  <= '0;
			acc_q  <= 32'd1;
			base_q <= a_q;
			exp_q  <= b_q;
			rem_q  <= '0;
			quo_q  <= ua;
			dvs_q  <= ub;
			na_q   <= a_q[31];
			nb_q   <= b_q[31];
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			case (op_q)
				OP_ADD: acc_q <= a_q + b_q;
				OP_SUB: acc_q <= a_q - b_q;
				OP_MUL: acc_q <= a_q * b_q;
				OP_POW: begin
					// One exponent bit per cycle, square and multiply.
					if (exp_q[0]) acc_q <= acc_q * base_q;
					base_q <= base_q * base_q;
					exp_q  <= exp_q >> 1;
				end
				OP_DIV, OP_MOD: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], quo_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_DIV: result = (na_q != nb_q) ? (32'd0 - quo_q) : quo_q;
			OP_MOD: result = na_q ? (32'd0 - rem_q) : rem_q;
			OP_POW: begin
				if (!nb_q) result = acc_q;
				else if (a_q == 32'd1) result = 32'd1;
				else if (a_q == 32'hFFFF_FFFF) result = b_q[0] ? 32'hFFFF_FFFF : 32'd1;
				else result = 32'd0;
			end
			default: result = acc_q;
		endcase
	end

	assign rd_data    = rdat_q;
	assign sts.done   = done_q;
	assign sts.b_zero = (b_q == 32'd0);
	assign sts.empty  = (level_q == '0);
	assign sts.full   = (level_q >= LW'(STACK_DEPTH));
	assign sts.lt2    = (level_q < LW'(2));

endmodule

FILE: rtl/core/pee_ctrl.sv
// Controller state machine of the postfix evaluator: token decode, error
// tracking and output register. Depends on pee_pkg.
module pee_ctrl import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  token,
	input  logic        last_token,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic [2:0]  status,
	output cmd_t        cmd,
	input  sts_t        sts,
	input  logic [31:0] rd_data
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RDB   = 8'b0000_0010,
		S_RDA   = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_EXEC  = 8'b0001_0000,
		S_FIN   = 8'b0010_0000,
		S_TOP   = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t     state_q;
	logic [7:0] tok_q;
	logic       last_q;
	logic [2:0] err_q;
	logic [1:0] wait_q;
	logic       ov_q;
	logic [31:0] val_q;
	logic [2:0]  st_q;

	op_t op;
	logic is_op, is_dig;
	always_comb begin
		is_dig = (tok_q inside {[ChZero:ChNine]});
		is_op  = 1'b1;
		case (tok_q)
			ChPlus:  op = OP_ADD;
			ChMinus: op = OP_SUB;
			ChMul:   op = OP_MUL;
			ChDiv:   op = OP_DIV;
			ChMod:   op = OP_MOD;
			ChPow:   op = OP_POW;
			default: begin op = OP_ADD; is_op = 1'b0; end
		endcase
	end

	logic [3:0] digit;
	assign digit = 4'(tok_q - ChZero);

	always_comb begin
		cmd = '0;
		cmd.op = op;
		cmd.digit = digit;
		case (state_q)
			S_RDB:  cmd.rd_b = 1'b1;
			S_RDA:  cmd.rd_a = 1'b1;
			S_EXEC: cmd.start = (wait_q == 2'd0);
			S_FIN:  cmd.wr_res = sts.done;
			S_TOP:  cmd.rd_top = 1'b1;
			default: ;
		endcase
		// Decode on the cycle after capture (state S_RDB covers decode).
		if (state_q == S_RDB && err_q == StOk && is_dig && !sts.full)
			cmd.push_dig = 1'b1;
		if (state_q == S_EMIT && !ov_q) cmd.clr = 1'b1;
	end

	// A waiting result only holds a last token back, in S_EMIT.
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign value     = val_q;
	assign status    = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= StOk;
			ov_q    <= 1'b0;
			wait_q  <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_RDB;
				S_RDB: begin
					if (err_q != StOk) state_q <= S_TOP;
					else if (is_dig) begin
						if (sts.full) err_q <= StOver;
						state_q <= S_TOP;
					end else if (!is_op) begin
						err_q <= StUnknown;
						state_q <= S_TOP;
					end else if (sts.lt2) begin
						err_q <= StUnder;
						state_q <= S_TOP;
					end else state_q <= S_RDA;
				end
				S_RDA: state_q <= S_CHK;
				S_CHK: begin
					// b is latched by now.
					if ((op == OP_DIV || op == OP_MOD) && sts.b_zero) begin
						err_q <= StZdiv;
						state_q <= S_TOP;
					end else begin
						wait_q  <= 2'd1;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// The wait_q count holds start back so a is latched before start.
					if (wait_q != 2'd0) wait_q <= wait_q - 2'd1;
					else state_q <= S_FIN;
				end
				S_FIN: if (sts.done) state_q <= S_TOP;
				S_TOP: state_q <= last_q ? S_EMIT : S_IDLE;
				S_EMIT: begin
					if (!ov_q) begin
						err_q   <= StOk;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tok_q  <= token;
			last_q <= last_token;
		end
		if (state_q == S_EMIT && !ov_q) begin
			if (err_q != StOk) begin
				st_q <= err_q; val_q <= '0;
			end else if (sts.empty) begin
				st_q <= StUnder; val_q <= '0;
			end else begin
				st_q <= StOk; val_q <= rd_data;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_emit_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(last_q)) else $error("result without last");
	a_no_push_on_err: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_dig |-> (err_q == StOk)) else $error("push during error");
`endif

endmodule

FILE: rtl/core/postfix_expression_evaluator_core.sv
// Top level of the postfix expression evaluator.
// Depends on pee_pkg, pee_ctrl and pee_datapath.
//
// Usage: one ASCII token is taken per input word on token/last_token with
// in_valid/in_ready. A digit pushes 0..9 onto the operand stack; + - * / % $
// pop b then a and push the 32-bit wrapped result. On a word with last_token
// set, one output word (value, status) is presented on out_valid/out_ready and
// the stack is emptied. The first error of an expression is kept; later
// tokens are skipped until the last one.
// Each word passes IDLE, RDB and TOP. A digit, a skipped token or a token
// rejected at decode goes from RDB straight to TOP; an operator otherwise
// passes RDA and CHK, where a zero divisor is caught, then EXEC and FIN, where / % $ run the
// one-bit-per-cycle divide and power loop. A last token adds EMIT, which
// places the result in the output register and sets out_valid with it.
// The block takes one word at a time; the next word is accepted once the
// previous is done, even while a result waits, except that a last token is
// held inside until the output register drains when the receiver stalls.
// Reset empties the stack and clears the error; stack contents are not cleared.
module postfix_expression_evaluator_core import pee_pkg::*; #(
	parameter int unsigned STACK_DEPTH = DefStackDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  token,
	input  logic        last_token,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic [2:0]  status
);
	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] rd_data;

	// The controller sequences each token; the datapath owns stack and unit.
	pee_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .token, .last_token,
		.out_valid, .out_ready, .value, .status,
		.cmd, .sts, .rd_data
	);

	pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .rd_data
	);

endmodule

FILE: test/postfix_expression_evaluator_checker.sv
// Checker for the postfix expression evaluator: watches both channels,
// predicts each result word from the accepted tokens and compares it.
// Depends on pee_pkg for token and status codes.
`timescale 1ns / 1ps
module postfix_expression_evaluator_checker import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  token,
	input  logic        last_token,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] value,
	input  logic [2:0]  status,
	output int          fail_count,
	output int          pending_count
);

	localparam int Depth = DefStackDepth;

	logic [31:0] eval_stack [Depth];
	int          eval_level;
	logic [2:0]  eval_error;
	logic [31:0] value_q  [$];
	logic [2:0]  status_q [$];

	function automatic logic [31:0] int_power(logic [31:0] a, logic [31:0] b);
		logic [31:0] acc;
		logic [31:0] base;
		acc = 32'd1;
		base = a;
		if (b[31]) begin
			if (a == 32'd1) return 32'd1;
			if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		while (b != 0) begin
			if (b[0]) acc = acc * base;
			base = base * base;
			b = b >> 1;
		end
		return acc;
	endfunction

	function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b,
			logic want_rem);
		logic [31:0] ua, ub, q, m;
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		q = ua / ub;
		m = ua % ub;
		if (a[31] != b[31]) q = -q;
		if (a[31]) m = -m;
		return want_rem ? m : q;
	endfunction

	task automatic apply_token(logic [7:0] tk);
		logic [31:0] a, b, r;
		if (tk >= ChZero && tk <= ChNine) begin
			if (eval_level >= Depth) begin
				eval_error = StOver;
			end else begin
				eval_stack[eval_level] = {24'd0, tk - ChZero};
				eval_level++;
			end
			return;
		end
		if (!(tk inside {ChPlus, ChMinus, ChMul, ChDiv, ChMod, ChPow})) begin
			eval_error = StUnknown;
			return;
		end
		if (eval_level < 2) begin
			eval_error = StUnder;
			return;
		end
		b = eval_stack[eval_level-1];
		a = eval_stack[eval_level-2];
		if ((tk == ChDiv || tk == ChMod) && b == 0) begin
			eval_error = StZdiv;
			return;
		end
		case (tk)
			ChPlus:  r = a + b;
			ChMinus: r = a - b;
			ChMul:   r = a * b;
			ChPow:   r = int_power(a, b);
			ChDiv:   r = signed_divide(a, b, 1'b0);
			default: r = signed_divide(a, b, 1'b1);
		endcase
		eval_stack[eval_level-2] = r;
		eval_level--;
	endtask

	assign pending_count = value_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] v;
		logic [2:0]  s;
		if (!arst_n) begin
			eval_level <= 0;
			eval_error <= StOk;
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (eval_error == StOk) apply_token(token);
				if (last_token) begin
					s = eval_error;
					v = 32'd0;
					if (s == StOk) begin
						if (eval_level == 0) s = StUnder;
						else v = eval_stack[eval_level-1];
					end
					value_q.push_back(v);
					status_q.push_back(s);
					eval_level = 0;
					eval_error = StOk;
				end
			end
			if (out_valid && out_ready) begin
				if (value_q.size() == 0) begin
					$display("%0t: unexpected word value=%h status=%0d", $time, value, status);
					fail_count <= fail_count + 1;
				end else begin
					v = value_q.pop_front();
					s = status_q.pop_front();
					if (v !== value || s !== status) begin
						$display("%0t: mismatch expected value=%h status=%0d, actual value=%h status=%0d",
							$time, v, s, value, status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: test/tb_top.sv
// Testbench top for the postfix expression evaluator: drives token words,
// drains result words and gives the verdict. Depends on pee_pkg, the core
// and postfix_expression_evaluator_checker.
`timescale 1ns / 1ps
module tb_top;
	import pee_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  token = ChZero;
	logic        last_token = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] value;
	logic [2:0]  status;
	int          fail_count;
	int          pending_count;

	// Set by the sender: while hold_off is high the receiver takes no word.
	logic        hold_off = 1'b0;
	// In the closing part of the run neither side idles.
	logic        no_idle = 1'b0;

	always #10 clk = ~clk;

	postfix_expression_evaluator_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.token(token), .last_token(last_token),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status)
	);

	postfix_expression_evaluator_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.token(token), .last_token(last_token),
		.out_valid(out_valid), .out_ready(out_ready),
		.value(value), .status(status),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// Offers one word and holds it, unchanged, until it has been accepted.
	// An idle burst may come first, so gaps land on every phase of the work.
	task automatic send_word(logic [7:0] tk, logic lst);
		int gap;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		token <= tk;
		last_token <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 5))
			0: return ChPlus;
			1: return ChMinus;
			2: return ChMul;
			3: return ChDiv;
			4: return ChMod;
			default: return ChPow;
		endcase
	endfunction

	function automatic logic [7:0] random_digit();
		return ChZero + 8'($urandom_range(0, 9));
	endfunction

	// A well-formed expression: operands and operators in a valid order, so
	// the stack never runs dry. Deeper pushes exercise a busier stack.
	task automatic send_expression(int operands);
		int level;
		int pushed;
		level = 0;
		pushed = 0;
		while (pushed < operands || level > 1) begin
			if (pushed < operands && (level < 2 || $urandom_range(0, 2) != 0)) begin
				pushed++;
				level++;
				send_word(random_digit(), (pushed == operands && level == 1));
			end else begin
				level--;
				send_word(random_operator(), (pushed == operands && level == 1));
			end
		end
	endtask

	// Leaves -2^31 and then -1 on the stack: 0 - 2^(9+9+9+4), then 0 - 1.
	task automatic push_most_negative();
		send_word("0", 1'b0); send_word("2", 1'b0);
		send_word("9", 1'b0); send_word("9", 1'b0); send_word("+", 1'b0);
		send_word("9", 1'b0); send_word("+", 1'b0);
		send_word("4", 1'b0); send_word("+", 1'b0);
		send_word("$", 1'b0);                        // 0, 2^31
		send_word("-", 1'b0);                        // -2^31
		send_word("0", 1'b0); send_word("1", 1'b0); send_word("-", 1'b0); // -1
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// Receiver: random stalls, a long forced stall, none near the end.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 13);
				out_ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int sent;
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: each operator, errors and edge cases.
		send_word("7", 1'b1);                              // single operand
		send_word("+", 1'b1);                              // empty underflow
		send_word("9", 1'b0); send_word("0", 1'b0); send_word("/", 1'b1); // zero divisor
		send_word("5", 1'b0); send_word("0", 1'b0); send_word("%", 1'b1);
		send_word("3", 1'b0); send_word("A", 1'b1);        // unknown symbol
		send_word(8'hFF, 1'b1);
		send_word("0", 1'b0); send_word("9", 1'b0); send_word("-", 1'b0);
		send_word("2", 1'b0); send_word("/", 1'b1);        // negative quotient
		send_word("0", 1'b0); send_word("9", 1'b0); send_word("-", 1'b0);
		send_word("4", 1'b0); send_word("%", 1'b1);        // remainder sign
		send_word("0", 1'b0); send_word("0", 1'b0); send_word("$", 1'b1); // 0^0
		send_word("0", 1'b0); send_word("1", 1'b0); send_word("-", 1'b0); // -1
		send_word("0", 1'b0); send_word("3", 1'b0); send_word("-", 1'b0);
		send_word("$", 1'b1);                              // (-1)^-3
		send_word("2", 1'b0); send_word("9", 1'b0); send_word("$", 1'b0);
		send_word("9", 1'b0); send_word("$", 1'b1);        // large wrap
		send_word("4", 1'b0); send_word("*", 1'b0); send_word("5", 1'b1); // sticky
		send_word("1", 1'b0); send_word("2", 1'b1);        // extra operands
		for (i = 0; i < 65; i++) send_word("8", i == 64);  // overflow
		wait_drained();

		// Most negative divided by minus one, then its remainder.
		push_most_negative();
		send_word("/", 1'b1);                        // wraps to -2^31
		push_most_negative();
		send_word("%", 1'b1);                        // remainder 0
		wait_drained();

		// Long receiver stall while tokens keep coming, so the block backs up.
		hold_off <= 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off <= 1'b0;
			end
			begin
				for (i = 0; i < 10; i++) send_expression($urandom_range(1, 3));
			end
		join
		wait_drained();

		// Random part: mostly well-formed expressions, some noise.
		sent = 0;
		while (sent < 1350) begin
			if (sent > 1150) no_idle <= 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				i = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 5);
				send_expression(i);
				sent += 2 * i - 1;
			end
		end
		// Close any partial expression left by noise.
		send_word("1", 1'b1);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pee_pkg.sv
rtl/core/pee_datapath.sv
rtl/core/pee_ctrl.sv
rtl/core/postfix_expression_evaluator_core.sv
test/postfix_expression_evaluator_checker.sv
test/tb_top.sv
